FILE: hdl/rotary_frequency_tuner_core_defines.svh
// Assertion macros for the rotary frequency tuner core.
`ifndef ROTARY_FREQUENCY_TUNER_CORE_DEFINES_SVH
`define ROTARY_FREQUENCY_TUNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RFT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rft: same-cycle check failed");
`define RFT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rft: next-cycle check failed");
`else
`define RFT_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RFT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/rft_pkg.sv
// Shared types, constants and tables for the rotary frequency tuner.
`default_nettype none
package rft_pkg;

    localparam int COUNT_BITS_DEF       = 10;
    localparam int FREQ_BITS_DEF        = 28;
    localparam int PRESS_TIMER_BITS_DEF = 16;

    localparam int BOUND_BITS    = 28;
    localparam int LONG_BITS     = 16;
    localparam int BLINK_BITS    = 10;
    localparam int STEP_BITS     = 3;
    localparam int COLUMN_BITS   = 4;
    localparam int DECADE_BITS   = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 28;

    localparam logic [BOUND_BITS-1:0] FREQ_MIN_RST      = 28'd8000;
    localparam logic [BOUND_BITS-1:0] FREQ_MAX_RST      = 28'd160000000;
    localparam logic [LONG_BITS-1:0]  LONG_PRESS_RST    = 16'd300;
    localparam logic [BLINK_BITS-1:0] CURSOR_SHOW_RST   = 10'd500;
    localparam logic [BLINK_BITS-1:0] CURSOR_PERIOD_RST = 10'd600;
    localparam logic [BLINK_BITS-1:0] BLINK_MAX         = 10'd1023;
    localparam logic [31:0]           CH0_FREQ_RST      = 32'd1000000;
    localparam logic [31:0]           CH1_FREQ_RST      = 32'd100000;
    localparam logic [STEP_BITS-1:0]  STEP_RST          = 3'd5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FREQ_MIN      = 3'd0,
        CFG_FREQ_MAX      = 3'd1,
        CFG_LONG_PRESS    = 3'd2,
        CFG_CURSOR_SHOW   = 3'd3,
        CFG_CURSOR_PERIOD = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [BOUND_BITS-1:0] freq_min;
        logic [BOUND_BITS-1:0] freq_max;
        logic [LONG_BITS-1:0]  long_press_ms;
        logic [BLINK_BITS-1:0] cursor_show_ms;
        logic [BLINK_BITS-1:0] cursor_period_ms;
    } cfg_t;

    function automatic logic [DECADE_BITS-1:0] decade_value(input logic [STEP_BITS-1:0] idx);
        logic [DECADE_BITS-1:0] v;
        unique case (idx)
            3'd0:    v = 24'd1;
            3'd1:    v = 24'd10;
            3'd2:    v = 24'd100;
            3'd3:    v = 24'd1000;
            3'd4:    v = 24'd10000;
            3'd5:    v = 24'd100000;
            3'd6:    v = 24'd1000000;
            3'd7:    v = 24'd10000000;
            default: v = 24'd1;
        endcase
        return v;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] decade_column(input logic [STEP_BITS-1:0] idx);
        logic [COLUMN_BITS-1:0] c;
        unique case (idx)
            3'd0:    c = 4'd14;
            3'd1:    c = 4'd13;
            3'd2:    c = 4'd12;
            3'd3:    c = 4'd10;
            3'd4:    c = 4'd9;
            3'd5:    c = 4'd8;
            3'd6:    c = 4'd6;
            3'd7:    c = 4'd5;
            default: c = 4'd14;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/rft_cfg_regs.sv
// Configuration register bank with a plain write port.
`default_nettype none
module rft_cfg_regs
    import rft_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_FREQ_MIN:      cfg_next.freq_min         = cfg_wdata[BOUND_BITS-1:0];
                CFG_FREQ_MAX:      cfg_next.freq_max         = cfg_wdata[BOUND_BITS-1:0];
                CFG_LONG_PRESS:    cfg_next.long_press_ms    = cfg_wdata[LONG_BITS-1:0];
                CFG_CURSOR_SHOW:   cfg_next.cursor_show_ms   = cfg_wdata[BLINK_BITS-1:0];
                CFG_CURSOR_PERIOD: cfg_next.cursor_period_ms = cfg_wdata[BLINK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.freq_min         <= FREQ_MIN_RST;
            cfg_reg.freq_max         <= FREQ_MAX_RST;
            cfg_reg.long_press_ms    <= LONG_PRESS_RST;
            cfg_reg.cursor_show_ms   <= CURSOR_SHOW_RST;
            cfg_reg.cursor_period_ms <= CURSOR_PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hdl/rft_pipe_reg.sv
// Single-entry pipeline register with valid/ready flow control.
`default_nettype none
module rft_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

FILE: hdl/rft_tune.sv
// Tuning state and the per-sample update of frequency, step, press and blink timers.
`default_nettype none
module rft_tune
    import rft_pkg::*;
#(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int FREQ_BITS        = FREQ_BITS_DEF,
    parameter int PRESS_TIMER_BITS = PRESS_TIMER_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step_en,
    input  wire cfg_t                  cfg,
    input  wire logic [COUNT_BITS-1:0] encoder_count,
    input  wire logic                  button_down,
    input  wire logic                  tick_ms,
    output logic                       freq_write,
    output logic                       write_channel,
    output logic [FREQ_BITS-1:0]       write_frequency,
    output logic                       selected_channel,
    output logic [FREQ_BITS-1:0]       shown_frequency,
    output logic [STEP_BITS-1:0]       step_decade,
    output logic [COLUMN_BITS-1:0]     cursor_column,
    output logic                       cursor_visible
);

    localparam int PROD_W = COUNT_BITS + DECADE_BITS + 1;
    localparam int W0     = (PROD_W > FREQ_BITS)
                            ? ((PROD_W > BOUND_BITS) ? PROD_W : BOUND_BITS)
                            : ((FREQ_BITS > BOUND_BITS) ? FREQ_BITS : BOUND_BITS);
    localparam int SUM_W  = W0 + 2;
    localparam int PW     = (PRESS_TIMER_BITS > LONG_BITS) ? PRESS_TIMER_BITS : LONG_BITS;

    logic [COUNT_BITS-1:0]       last_count_reg, last_count_next;
    logic                        primed_reg, primed_next;
    logic [FREQ_BITS-1:0]        freq0_reg, freq0_next;
    logic [FREQ_BITS-1:0]        freq1_reg, freq1_next;
    logic                        channel_sel_reg, channel_sel_next;
    logic [STEP_BITS-1:0]        step_index_reg, step_index_next;
    logic                        button_held_reg, button_held_next;
    logic [PRESS_TIMER_BITS-1:0] press_timer_reg, press_timer_next;
    logic [BLINK_BITS-1:0]       blink_timer_reg, blink_timer_next;

    logic [COUNT_BITS-1:0]        last_eff;
    logic [COUNT_BITS-1:0]        diff;
    logic signed [COUNT_BITS-1:0] delta;
    logic signed [DECADE_BITS:0]  step_val;
    logic signed [PROD_W-1:0]     prod;
    logic [FREQ_BITS-1:0]         cur_freq;
    logic signed [SUM_W-1:0]      sum;
    logic signed [SUM_W-1:0]      lo_bound;
    logic signed [SUM_W-1:0]      hi_bound;
    logic                         in_range;
    logic                         wrote;
    logic [PRESS_TIMER_BITS-1:0]  press_inc;
    logic [BLINK_BITS-1:0]        blink_inc;
    logic                         visible;

    assign last_eff = primed_reg ? last_count_reg : encoder_count;
    assign diff     = encoder_count - last_eff;
    assign delta    = $signed(diff);
    assign step_val = $signed({1'b0, decade_value(step_index_reg)});
    assign prod     = PROD_W'(delta) * PROD_W'(step_val);
    assign cur_freq = channel_sel_reg ? freq1_reg : freq0_reg;
    assign sum      = $signed({{(SUM_W-FREQ_BITS){1'b0}}, cur_freq}) + SUM_W'(prod);
    assign lo_bound = $signed({{(SUM_W-BOUND_BITS){1'b0}}, cfg.freq_min});
    assign hi_bound = $signed({{(SUM_W-BOUND_BITS){1'b0}}, cfg.freq_max});
    assign in_range = (sum > lo_bound) && (sum < hi_bound);
    assign wrote    = !button_held_reg && (diff != '0) && in_range;

    assign press_inc = (tick_ms && (press_timer_reg != '1))
                       ? press_timer_reg + PRESS_TIMER_BITS'(1) : press_timer_reg;
    assign blink_inc = (tick_ms && (blink_timer_reg != BLINK_MAX))
                       ? blink_timer_reg + BLINK_BITS'(1) : blink_timer_reg;

    always_comb begin
        last_count_next  = last_count_reg;
        primed_next      = 1'b1;
        freq0_next       = freq0_reg;
        freq1_next       = freq1_reg;
        channel_sel_next = channel_sel_reg;
        step_index_next  = step_index_reg;
        button_held_next = button_held_reg;
        press_timer_next = press_timer_reg;
        blink_timer_next = blink_timer_reg;
        visible          = 1'b0;

        if (!primed_reg) begin
            last_count_next = encoder_count;
        end

        if (!button_held_reg) begin
            if (diff != '0) begin
                last_count_next = encoder_count;
                if (in_range) begin
                    if (channel_sel_reg) begin
                        freq1_next = sum[FREQ_BITS-1:0];
                    end else begin
                        freq0_next = sum[FREQ_BITS-1:0];
                    end
                end
            end
            if (button_down) begin
                button_held_next = 1'b1;
                press_timer_next = '0;
            end
        end else begin
            press_timer_next = press_inc;
            if (!button_down) begin
                button_held_next = 1'b0;
                if (PW'(press_inc) > PW'(cfg.long_press_ms)) begin
                    channel_sel_next = !channel_sel_reg;
                end else begin
                    step_index_next = step_index_reg + STEP_BITS'(1);
                end
            end
        end

        if (wrote) begin
            blink_timer_next = '0;
        end else if (blink_inc > cfg.cursor_period_ms) begin
            blink_timer_next = '0;
        end else begin
            blink_timer_next = blink_inc;
            visible          = blink_inc > cfg.cursor_show_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg  <= '0;
            primed_reg      <= 1'b0;
            freq0_reg       <= FREQ_BITS'(CH0_FREQ_RST);
            freq1_reg       <= FREQ_BITS'(CH1_FREQ_RST);
            channel_sel_reg <= 1'b0;
            step_index_reg  <= STEP_RST;
            button_held_reg <= 1'b0;
            press_timer_reg <= '0;
            blink_timer_reg <= '0;
        end else if (step_en) begin
            last_count_reg  <= last_count_next;
            primed_reg      <= primed_next;
            freq0_reg       <= freq0_next;
            freq1_reg       <= freq1_next;
            channel_sel_reg <= channel_sel_next;
            step_index_reg  <= step_index_next;
            button_held_reg <= button_held_next;
            press_timer_reg <= press_timer_next;
            blink_timer_reg <= blink_timer_next;
        end
    end

    assign selected_channel = channel_sel_next;
    assign shown_frequency  = channel_sel_next ? freq1_next : freq0_next;
    assign freq_write       = wrote;
    assign write_channel    = wrote ? channel_sel_next : 1'b0;
    assign write_frequency  = wrote ? shown_frequency : '0;
    assign step_decade      = step_index_next;
    assign cursor_column    = decade_column(step_index_next);
    assign cursor_visible   = visible;

endmodule
`default_nettype wire

FILE: hdl/rotary_frequency_tuner_core.sv
// Rotary frequency tuner: sample register, tuning update and result register.
// Flow: a sample is held in the sample register, its result in the result register, which
// drives m_tvalid; a full result register with m_tready low stalls the samples.
// Throughput: one sample per cycle unless so stalled; the tuning update is a single pass
// between registers. The multiply of the count delta by the step sets the critical path.
// Reset: synchronous, active-low aresetn clears both valid flags, restores the
// configuration and tuning state to their defaults; no clearing pass is needed.
`default_nettype none
`include "rotary_frequency_tuner_core_defines.svh"
module rotary_frequency_tuner_core
    import rft_pkg::*;
#(
    parameter int COUNT_BITS       = COUNT_BITS_DEF,
    parameter int FREQ_BITS        = FREQ_BITS_DEF,
    parameter int PRESS_TIMER_BITS = PRESS_TIMER_BITS_DEF,
    localparam int IN_RAW          = COUNT_BITS + 2,
    localparam int IN_W            = ((IN_RAW + 7) / 8) * 8,
    localparam int OUT_RAW         = 2 * FREQ_BITS + STEP_BITS + COLUMN_BITS + 4,
    localparam int OUT_W           = ((OUT_RAW + 7) / 8) * 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // encoder_count, button_down, tick_ms
    input  wire logic [IN_W-1:0]          s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // freq_write, write_channel, write_frequency, selected_channel,
    // shown_frequency, step_decade, cursor_column, cursor_visible
    output logic [OUT_W-1:0]              m_tdata
);

    localparam int VIS_BIT = OUT_RAW - 1;

    cfg_t                  cfg;
    logic                  smp_valid;
    logic                  res_ready;
    logic                  step_en;
    logic [IN_RAW-1:0]     smp_data;
    logic [OUT_RAW-1:0]    res_data;
    logic [OUT_RAW-1:0]    res_q;

    logic                  freq_write;
    logic                  write_channel;
    logic [FREQ_BITS-1:0]  write_frequency;
    logic                  selected_channel;
    logic [FREQ_BITS-1:0]  shown_frequency;
    logic [STEP_BITS-1:0]  step_decade;
    logic [COLUMN_BITS-1:0] cursor_column;
    logic                  cursor_visible;

    rft_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rft_pipe_reg #(.WIDTH(IN_RAW)) u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[IN_RAW-1:0]),
        .out_valid (smp_valid),
        .out_ready (res_ready),
        .out_data  (smp_data)
    );

    assign step_en = smp_valid && res_ready;

    rft_tune #(
        .COUNT_BITS       (COUNT_BITS),
        .FREQ_BITS        (FREQ_BITS),
        .PRESS_TIMER_BITS (PRESS_TIMER_BITS)
    ) u_tune (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (step_en),
        .cfg              (cfg),
        .encoder_count    (smp_data[COUNT_BITS-1:0]),
        .button_down      (smp_data[COUNT_BITS]),
        .tick_ms          (smp_data[COUNT_BITS+1]),
        .freq_write       (freq_write),
        .write_channel    (write_channel),
        .write_frequency  (write_frequency),
        .selected_channel (selected_channel),
        .shown_frequency  (shown_frequency),
        .step_decade      (step_decade),
        .cursor_column    (cursor_column),
        .cursor_visible   (cursor_visible)
    );

    assign res_data = {cursor_visible, cursor_column, step_decade, shown_frequency,
                       selected_channel, write_frequency, write_channel, freq_write};

    rft_pipe_reg #(.WIDTH(OUT_RAW)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (smp_valid),
        .in_ready  (res_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_q)
    );

    assign m_tdata = {{(OUT_W-OUT_RAW){1'b0}}, res_q};

    `RFT_ASSERT_NEXT(a_result_follows_update, aclk, aresetn, step_en, m_tvalid)
    `RFT_ASSERT_IMPL(a_stall_only_when_full, aclk, aresetn, !s_tready, smp_valid && m_tvalid && !m_tready)
    `RFT_ASSERT_IMPL(a_cursor_hidden_on_write, aclk, aresetn, m_tvalid && m_tdata[0], !m_tdata[VIS_BIT])

endmodule
`default_nettype wire
